// ===== rtl/named_repeating_timer_table_defines.svh =====
// Assertion macros shared by the timer table checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef NAMED_REPEATING_TIMER_TABLE_DEFINES_SVH
`define NAMED_REPEATING_TIMER_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define NRTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define NRTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/nrtt_pkg.sv =====
// Shared constants and types for the timer table.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package nrtt_pkg;
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_RM_KEY  = 3'd1;
  localparam logic [2:0] CMD_RM_SLOT = 3'd2;
  localparam logic [2:0] CMD_CLEAR   = 3'd3;
  localparam logic [2:0] CMD_TICK    = 3'd4;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_FIRE = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [16:0] FOREVER = 17'h1FFFF;
  localparam logic [47:0] MAX48   = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        due;     // now_ms >= deadline
    logic [47:0] reload;  // now_ms + interval, saturated
  } alu_res_t;
endpackage
`default_nettype wire

// ===== rtl/nrtt_alu.sv =====
// Shared time unit: due compare and saturated deadline reload.
// Depends on nrtt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nrtt_alu (
  input  wire logic [47:0]       now_ms,
  input  wire logic [47:0]       deadline,
  input  wire logic [31:0]       interval,
  output nrtt_pkg::alu_res_t     res
);
  logic [48:0] sum;

  assign sum        = {1'b0, now_ms} + {17'd0, interval};
  assign res.due    = (now_ms >= deadline);
  assign res.reload = sum[48] ? nrtt_pkg::MAX48 : sum[47:0];
endmodule
`default_nettype wire

// ===== rtl/named_repeating_timer_table.sv =====
// Top level of the keyed timer table: command sequencer and entry storage.
// Depends on nrtt_pkg and nrtt_alu.
//
// A command is taken when start is high and busy is low. Clear, an invalid add,
// a bad slot, a zero key for remove and unknown codes answer in the next cycle and
// leave busy low. Add, remove by key and remove by slot walk the table once; add
// uses the shared time unit. Tick walks it twice, once to count the timers that
// expire and once to fire, reload and compact. Results appear at most one per
// cycle on strobe and cannot be held off; the last one of a command carries last.
`timescale 1ns / 1ps
`default_nettype none
module named_repeating_timer_table (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         command,
  input  wire logic [15:0]        key,
  input  wire logic [31:0]        payload,
  input  wire logic [47:0]        first_fire_ms,
  input  wire logic [47:0]        now_ms,
  input  wire logic [31:0]        interval,
  input  wire logic signed [16:0] repeat_count,
  input  wire logic [3:0]         slot_index,
  output logic                    strobe,
  output logic [1:0]              kind,
  output logic                    ok,
  output logic [15:0]             fired_key,
  output logic [31:0]             fired_payload,
  output logic [4:0]              entries_left,
  output logic                    last
);
  localparam int DEPTH = nrtt_pkg::TABLE_DEPTH;
  localparam int IW = nrtt_pkg::IDX_W;
  localparam int CW = nrtt_pkg::CNT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_COUNT = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  logic [1:0]  state;
  logic [2:0]  cmd_r;
  logic [15:0] key_r;
  logic [31:0] pay_r;
  logic [47:0] start_r;
  logic [47:0] now_r;
  logic [31:0] intv_r;
  logic [16:0] rc_r;
  logic [3:0]  slot_r;
  logic [CW-1:0] i, w, count, final_cnt;
  logic        found;

  logic [15:0] e_key [DEPTH];
  logic [31:0] e_pay [DEPTH];
  logic [31:0] e_int [DEPTH];
  logic [16:0] e_rem [DEPTH];
  logic [47:0] e_dl  [DEPTH];

  logic [15:0] rd_key;
  logic [31:0] rd_pay, rd_int;
  logic [16:0] rd_rem, rem_next;
  logic [47:0] rd_dl, alu_dl, add_dl;
  logic [31:0] alu_int;
  logic        in_range, add_valid, rc_ok, expire;
  nrtt_pkg::alu_res_t alu;

  assign rd_key = e_key[i[IW-1:0]];
  assign rd_pay = e_pay[i[IW-1:0]];
  assign rd_int = e_int[i[IW-1:0]];
  assign rd_rem = e_rem[i[IW-1:0]];
  assign rd_dl  = e_dl[i[IW-1:0]];

  assign in_range = (i < count);
  assign busy = (state != ST_IDLE);

  // Add borrows the unit to compare the first-fire time and build the default deadline.
  assign alu_dl  = (cmd_r == nrtt_pkg::CMD_ADD) ? start_r : rd_dl;
  assign alu_int = (cmd_r == nrtt_pkg::CMD_ADD) ? intv_r : rd_int;

  nrtt_alu u_alu (
    .now_ms   (now_r),
    .deadline (alu_dl),
    .interval (alu_int),
    .res      (alu)
  );

  assign add_dl   = ((start_r != 48'd0) && !alu.due) ? start_r : alu.reload;
  assign rem_next = (rd_rem == nrtt_pkg::FOREVER) ? rd_rem : rd_rem - 17'd1;
  assign expire   = alu.due && (rd_rem == 17'd1);

  assign rc_ok = (repeat_count != 17'sd0) &&
                 (!repeat_count[16] || (repeat_count == nrtt_pkg::FOREVER));
  assign add_valid = (key != 16'd0) && (payload != 32'd0) && (interval != 32'd0) && rc_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_r   <= command;
            key_r   <= key;
            pay_r   <= payload;
            start_r <= first_fire_ms;
            now_r   <= now_ms;
            intv_r  <= interval;
            rc_r    <= repeat_count;
            slot_r  <= slot_index;
            i       <= '0;
            w       <= '0;
            found   <= 1'b0;
            final_cnt <= count;
            fired_key     <= '0;
            fired_payload <= '0;
            kind          <= nrtt_pkg::KIND_ACK;
            last          <= 1'b1;
            ok            <= 1'b0;
            entries_left  <= 5'(count);
            case (command)
              nrtt_pkg::CMD_ADD: begin
                if (add_valid) state <= ST_SCAN;
                else strobe <= 1'b1;
              end
              nrtt_pkg::CMD_RM_KEY: begin
                if (key != 16'd0) state <= ST_SCAN;
                else strobe <= 1'b1;
              end
              nrtt_pkg::CMD_RM_SLOT: begin
                if (CW'(slot_index) < count && 5'(slot_index) < 5'(count)) state <= ST_SCAN;
                else strobe <= 1'b1;
              end
              nrtt_pkg::CMD_CLEAR: begin
                strobe       <= 1'b1;
                ok           <= (count != '0);
                entries_left <= '0;
                count        <= '0;
              end
              nrtt_pkg::CMD_TICK: begin
                state <= ST_COUNT;
              end
              default: begin
                strobe <= 1'b1;
              end
            endcase
          end
        end

        ST_COUNT: begin
          if (in_range) begin
            if (expire) final_cnt <= final_cnt - CW'(1);
            i <= i + CW'(1);
          end else begin
            i     <= '0;
            state <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          if (in_range) begin
            i <= i + CW'(1);
            case (cmd_r)
              nrtt_pkg::CMD_ADD: begin
                if (rd_key == key_r) begin
                  found <= 1'b1;
                  e_pay[i[IW-1:0]] <= pay_r;
                  e_int[i[IW-1:0]] <= intv_r;
                  e_rem[i[IW-1:0]] <= rc_r;
                  e_dl[i[IW-1:0]]  <= add_dl;
                end
              end
              nrtt_pkg::CMD_TICK: begin
                if (alu.due) begin
                  strobe        <= 1'b1;
                  kind          <= nrtt_pkg::KIND_FIRE;
                  ok            <= 1'b1;
                  last          <= 1'b0;
                  fired_key     <= rd_key;
                  fired_payload <= rd_pay;
                  entries_left  <= 5'(final_cnt);
                end
                if (!expire) begin
                  e_key[w[IW-1:0]] <= rd_key;
                  e_pay[w[IW-1:0]] <= rd_pay;
                  e_int[w[IW-1:0]] <= rd_int;
                  e_rem[w[IW-1:0]] <= alu.due ? rem_next : rd_rem;
                  e_dl[w[IW-1:0]]  <= alu.due ? alu.reload : rd_dl;
                  w <= w + CW'(1);
                end
              end
              default: begin
                // remove by key or by slot: drop one entry, shift the rest down
                if (!found && (((cmd_r == nrtt_pkg::CMD_RM_KEY) && (rd_key == key_r)) ||
                               ((cmd_r == nrtt_pkg::CMD_RM_SLOT) && (CW'(slot_r) == i)))) begin
                  found <= 1'b1;
                end else begin
                  e_key[w[IW-1:0]] <= rd_key;
                  e_pay[w[IW-1:0]] <= rd_pay;
                  e_int[w[IW-1:0]] <= rd_int;
                  e_rem[w[IW-1:0]] <= rd_rem;
                  e_dl[w[IW-1:0]]  <= rd_dl;
                  w <= w + CW'(1);
                end
              end
            endcase
          end else begin
            state         <= ST_IDLE;
            strobe        <= 1'b1;
            last          <= 1'b1;
            fired_key     <= '0;
            fired_payload <= '0;
            case (cmd_r)
              nrtt_pkg::CMD_ADD: begin
                kind <= nrtt_pkg::KIND_ACK;
                if (found) begin
                  ok           <= 1'b1;
                  entries_left <= 5'(count);
                end else if (count < CW'(DEPTH)) begin
                  e_key[count[IW-1:0]] <= key_r;
                  e_pay[count[IW-1:0]] <= pay_r;
                  e_int[count[IW-1:0]] <= intv_r;
                  e_rem[count[IW-1:0]] <= rc_r;
                  e_dl[count[IW-1:0]]  <= add_dl;
                  count        <= count + CW'(1);
                  ok           <= 1'b1;
                  entries_left <= 5'(count + CW'(1));
                end else begin
                  ok           <= 1'b0;
                  entries_left <= 5'(count);
                end
              end
              nrtt_pkg::CMD_TICK: begin
                kind         <= nrtt_pkg::KIND_DONE;
                ok           <= 1'b1;
                count        <= w;
                entries_left <= 5'(w);
              end
              default: begin
                kind         <= nrtt_pkg::KIND_ACK;
                ok           <= found;
                count        <= w;
                entries_left <= 5'(w);
              end
            endcase
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/nrtt_checker.sv =====
// Port-level checks of the timer table, bound to the top level.
// Depends on nrtt_pkg and named_repeating_timer_table_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "named_repeating_timer_table_defines.svh"
module nrtt_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               strobe,
  input wire logic [1:0]         kind,
  input wire logic               ok,
  input wire logic [15:0]        fired_key,
  input wire logic [31:0]        fired_payload,
  input wire logic [4:0]         entries_left,
  input wire logic               last
);
  // every request either answers at once or holds busy
  `NRTT_ASSERT_NEXT(a_req_progress, start && !busy, busy || strobe, "request dropped")
  `NRTT_ASSERT_NOW(a_fire_midway, strobe && (kind == nrtt_pkg::KIND_FIRE), busy && !last && ok, "fire outside tick")
  `NRTT_ASSERT_NOW(a_single_last, strobe && (kind != nrtt_pkg::KIND_FIRE), last, "final result lacks last")
  `NRTT_ASSERT_NOW(a_quiet_fields, strobe && (kind != nrtt_pkg::KIND_FIRE), (fired_key == 16'd0) && (fired_payload == 32'd0), "stale fire fields")
  `NRTT_ASSERT_NOW(a_count_range, strobe, entries_left <= 5'(nrtt_pkg::TABLE_DEPTH), "count overflow")
endmodule

bind named_repeating_timer_table nrtt_checker u_nrtt_checker (.*);
`default_nettype wire
